// ===== sv/lfr_pkg.sv =====
package lfr_pkg;

  localparam int unsigned MaxDataBytesDefault = 8;
  localparam int unsigned BitTimeW            = 10;
  localparam int unsigned LowTimeW            = 16;
  localparam int unsigned ThresholdW          = 14;

  localparam logic [BitTimeW-1:0] BitTimeReset = 10'd52;

  localparam logic [7:0] BreakByte  = 8'h00;
  localparam logic [7:0] SyncByte   = 8'h55;
  localparam logic [7:0] IdMask     = 8'h3F;
  localparam logic [7:0] ParityMask = 8'hC0;

  // configuration register indexes
  typedef enum logic {
    CFG_BIT_TIME          = 1'b0,
    CFG_CHECKSUM_ENHANCED = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ARMED = 3'd1,
    PH_SYNC  = 3'd2,
    PH_IDENT = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SYNC_ERR   = 2'd1,
    ST_PARITY_ERR = 2'd2,
    ST_CSUM_ERR   = 2'd3
  } status_e;

  typedef enum logic {
    RPT_HEADER = 1'b0,
    RPT_FRAME  = 1'b1
  } report_kind_e;

  typedef enum logic {
    KIND_LINE_RISE = 1'b0,
    KIND_BYTE      = 1'b1
  } item_kind_e;

  // one report word
  typedef struct packed {
    logic       report_kind;
    logic [1:0] status;
    logic [5:0] frame_id;
    logic [3:0] data_length;
    logic [63:0] data_bytes;
    logic [7:0] received_checksum;
  } lfr_result_t;

  // expected parity bits 7:6 for a six-bit identifier
  function automatic logic [7:0] parity_bits(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, 6'd0};
  endfunction

  // end-around-carry byte add
  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  // low time threshold: eleven bit times
  function automatic logic [ThresholdW-1:0] break_threshold(input logic [BitTimeW-1:0] bt);
    logic [ThresholdW-1:0] x;
    x = ThresholdW'(bt);
    return (x << 3) + (x << 1) + x;
  endfunction

endpackage

// ===== sv/lin_frame_receiver_unit.sv =====
// LIN responder frame receiver. Feed it line-release events (with the measured
// low time) and UART bytes; it reports each header (status ok, sync error or
// parity error) and each complete frame (ok or checksum error, with data and
// the received checksum). One word is accepted per clock. A word is held
// in the input register, then its report, if any, lands in a two-word output
// buffer, from which the report can be taken while out_stall_i is low.
// The input stalls only while that output buffer holds two untaken reports.
// Configuration (bit time, enhanced checksum) is written through its own port,
// which is always ready; write it only while the block is idle.
module lin_frame_receiver_unit import lfr_pkg::*; #(
  parameter int unsigned MaxDataBytes = MaxDataBytesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [LowTimeW-1:0]   low_time_us_i,
  input  logic [7:0]            rx_byte_i,
  // reports
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  report_kind_o,
  output logic [1:0]            status_o,
  output logic [5:0]            frame_id_o,
  output logic [3:0]            data_length_o,
  output logic [8*MaxDataBytes-1:0] data_bytes_o,
  output logic [7:0]            received_checksum_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [BitTimeW-1:0]   cfg_data_i
);

  logic [BitTimeW-1:0] bit_time_q;
  logic                enhanced_q;
  logic                push;
  logic                full;
  lfr_result_t         core_word;
  lfr_result_t         out_word;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q <= BitTimeReset;
      enhanced_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_BIT_TIME:          bit_time_q <= cfg_data_i;
        CFG_CHECKSUM_ENHANCED: enhanced_q <= cfg_data_i[0];
        default:               bit_time_q <= bit_time_q;
      endcase
    end
  end

  lfr_core #(
    .MaxDataBytes(MaxDataBytes)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .low_time_us_i       (low_time_us_i),
    .rx_byte_i           (rx_byte_i),
    .bit_time_i          (bit_time_q),
    .checksum_enhanced_i (enhanced_q),
    .buf_full_i          (full),
    .push_o              (push),
    .result_o            (core_word)
  );

  lfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (core_word),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word)
  );

  assign report_kind_o       = out_word.report_kind;
  assign status_o            = out_word.status;
  assign frame_id_o          = out_word.frame_id;
  assign data_length_o       = out_word.data_length;
  assign data_bytes_o        = out_word.data_bytes[8*MaxDataBytes-1:0];
  assign received_checksum_o = out_word.received_checksum;

endmodule

// ===== sv/lfr_core.sv =====
module lfr_core import lfr_pkg::*; #(
  parameter int unsigned MaxDataBytes = MaxDataBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [LowTimeW-1:0] low_time_us_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [BitTimeW-1:0] bit_time_i,
  input  logic                checksum_enhanced_i,
  input  logic                buf_full_i,
  output logic                push_o,
  output lfr_result_t         result_o
);

  localparam int unsigned IdxW  = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;
  localparam int unsigned DataW = 8 * MaxDataBytes;

  // input register
  logic                in_valid_q;
  logic                in_kind_q;
  logic [LowTimeW-1:0] in_low_q;
  logic [7:0]          in_byte_q;
  logic                adv;
  logic                in_accept;

  assign adv        = in_valid_q & ~buf_full_i;
  assign in_stall_o = in_valid_q & buf_full_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_kind_q <= kind_i;
      in_low_q  <= low_time_us_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // frame state
  phase_e            phase_q, phase_d;
  logic [7:0]        pid_q, pid_d;
  logic [3:0]        exp_len_q, exp_len_d;
  logic [3:0]        count_q, count_d;
  logic [DataW-1:0]  data_q, data_d;
  logic [7:0]        sum_q, sum_d;

  logic                  is_break;
  logic [3:0]            count_inc;
  logic [IdxW-1:0]       lane;
  logic [7:0]            len_code;

  assign is_break  = {2'b00, break_threshold(bit_time_i)} < in_low_q;
  assign count_inc = count_q + 4'd1;
  assign lane      = count_q[IdxW-1:0];

  always_comb begin
    unique case (in_byte_q[5:4])
      2'd0, 2'd1: len_code = 8'd2;
      2'd2:       len_code = 8'd4;
      default:    len_code = 8'(MaxDataBytes);
    endcase
  end

  // next state and report
  always_comb begin
    phase_d   = phase_q;
    pid_d     = pid_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    data_d    = data_q;
    sum_d     = sum_q;
    push_o    = 1'b0;
    result_o  = '0;
    if (adv) begin
      if (in_kind_q == KIND_LINE_RISE) begin
        if (is_break) begin
          phase_d = PH_ARMED;
        end
      end else begin
        unique case (phase_q)
          PH_ARMED: begin
            if (in_byte_q == BreakByte) begin
              phase_d = PH_SYNC;
            end
          end
          PH_SYNC: begin
            if (in_byte_q == SyncByte) begin
              phase_d = PH_IDENT;
            end else begin
              push_o          = 1'b1;
              result_o.status = ST_SYNC_ERR;
              phase_d         = PH_IDLE;
            end
          end
          PH_IDENT: begin
            push_o            = 1'b1;
            pid_d             = in_byte_q;
            result_o.frame_id = in_byte_q[5:0];
            if (parity_bits(in_byte_q[5:0]) != (in_byte_q & ParityMask)) begin
              result_o.status = ST_PARITY_ERR;
              phase_d         = PH_IDLE;
            end else begin
              exp_len_d = len_code[3:0];
              count_d   = '0;
              data_d    = '0;
              sum_d     = checksum_enhanced_i ? in_byte_q : 8'd0;
              phase_d   = PH_DATA;
            end
          end
          PH_DATA: begin
            for (int unsigned i = 0; i < MaxDataBytes; i++) begin
              if (lane == IdxW'(i)) begin
                data_d[8*i +: 8] = data_q[8*i +: 8] | in_byte_q;
              end
            end
            sum_d   = add_carry(sum_q, in_byte_q);
            count_d = count_inc;
            if (count_inc >= exp_len_q) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            push_o                     = 1'b1;
            result_o.report_kind       = RPT_FRAME;
            result_o.status            = (in_byte_q == ~sum_q) ? ST_OK : ST_CSUM_ERR;
            result_o.frame_id          = pid_q[5:0];
            result_o.data_length       = exp_len_q;
            result_o.data_bytes        = 64'(data_q);
            result_o.received_checksum = in_byte_q;
            phase_d                    = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pid_q     <= '0;
      exp_len_q <= '0;
      count_q   <= '0;
      data_q    <= '0;
      sum_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      pid_q     <= pid_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
      data_q    <= data_d;
      sum_q     <= sum_d;
    end
  end

  // line events never produce a report
  a_line_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_kind_q == KIND_LINE_RISE) |-> !push_o)
    else $error("report pushed for a line event");

  // nothing is pushed into a full buffer
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (in_valid_q && !buf_full_i))
    else $error("report pushed without room");

  // a bad sync byte returns to idle
  a_sync_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_kind_q == KIND_BYTE && phase_q == PH_SYNC && in_byte_q != SyncByte)
      |=> phase_q == PH_IDLE)
    else $error("sync error did not return to idle");

  // the data count never runs past the frame length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (count_q < exp_len_q))
    else $error("data count beyond frame length");

endmodule

// ===== sv/lfr_out_buf.sv =====
module lfr_out_buf import lfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lfr_result_t push_word_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lfr_result_t out_word_o
);

  // two-word buffer, so the core keeps going while one report waits
  lfr_result_t mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        pop;

  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q == 2'd2;
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      priority if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end else begin
        count_q <= count_q;
      end
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("buffer count overflow");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full buffer");

  a_ptrs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("buffer pointers out of step");

endmodule

// ===== bench/tb_top.sv =====
import lfr_pkg::*;

// protected identifier: parity bits 7:6 over the six-bit id
function automatic logic [7:0] lin_pid(input logic [5:0] id);
  logic p0;
  logic p1;
  p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
  p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
  return {p1, p0, id};
endfunction

// byte add with end-around carry
function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
  logic [8:0] t;
  t = {1'b0, a} + {1'b0, b};
  return t[7:0] + {7'd0, t[8]};
endfunction

// data length from id bits 5:4
function automatic logic [3:0] id_data_len(input logic [5:0] id);
  case (id[5:4])
    2'd2: return 4'd4;
    2'd3: return 4'd8;
    default: return 4'd2;
  endcase
endfunction

// Tracks the receiver state word by word and holds the reports still due.
class lin_report_checker;
  logic [BitTimeW-1:0] bit_time;
  logic                enhanced;
  phase_e              phase;
  logic [7:0]          pid;
  logic [3:0]          frame_len;
  logic [3:0]          byte_cnt;
  logic [63:0]         payload;
  logic [7:0]          sum;
  lfr_result_t         due_reports[$];
  int unsigned         failures;
  int unsigned         headers;
  int unsigned         frames;
  int unsigned         csum_errors;

  function new();
    bit_time    = BitTimeReset;
    enhanced    = 1'b0;
    phase       = PH_IDLE;
    pid         = '0;
    frame_len   = '0;
    byte_cnt    = '0;
    payload     = '0;
    sum         = '0;
    failures    = 0;
    headers     = 0;
    frames      = 0;
    csum_errors = 0;
  endfunction

  function void set_config(input cfg_index_e idx, input logic [BitTimeW-1:0] d);
    case (idx)
      CFG_BIT_TIME:          bit_time = d;
      CFG_CHECKSUM_ENHANCED: enhanced = d[0];
      default: ;
    endcase
  endfunction

  // advance on one accepted word, queue the report it causes
  function void take_word(input item_kind_e k, input logic [LowTimeW-1:0] lt,
                          input logic [7:0] b);
    lfr_result_t r;
    int unsigned thr;
    r = '0;
    if (k == KIND_LINE_RISE) begin
      thr = 32'(bit_time) * 11;
      if (32'(lt) > thr) phase = PH_ARMED;
      return;
    end
    case (phase)
      PH_ARMED: begin
        if (b == BreakByte) phase = PH_SYNC;
      end
      PH_SYNC: begin
        if (b == SyncByte) begin
          phase = PH_IDENT;
        end else begin
          r.report_kind = RPT_HEADER;
          r.status = ST_SYNC_ERR;
          due_reports.push_back(r);
          phase = PH_IDLE;
        end
      end
      PH_IDENT: begin
        pid = b;
        r.report_kind = RPT_HEADER;
        r.frame_id = b[5:0];
        if (lin_pid(b[5:0]) != b) begin
          r.status = ST_PARITY_ERR;
          phase = PH_IDLE;
        end else begin
          r.status = ST_OK;
          frame_len = id_data_len(b[5:0]);
          byte_cnt = '0;
          payload = '0;
          sum = enhanced ? b : 8'h00;
          phase = PH_DATA;
        end
        due_reports.push_back(r);
      end
      PH_DATA: begin
        payload = payload | (64'(b) << (8 * byte_cnt[2:0]));
        sum = eac_add(sum, b);
        byte_cnt = byte_cnt + 4'd1;
        if (byte_cnt >= frame_len) phase = PH_CSUM;
      end
      PH_CSUM: begin
        r.report_kind = RPT_FRAME;
        r.status = (b == ~sum) ? ST_OK : ST_CSUM_ERR;
        r.frame_id = pid[5:0];
        r.data_length = frame_len;
        r.data_bytes = payload;
        r.received_checksum = b;
        due_reports.push_back(r);
        phase = PH_IDLE;
      end
      default: phase = PH_IDLE;
    endcase
  endfunction

  function void fail_note(input string msg);
    if (failures < 10) $display("MISMATCH: %s", msg);
    failures++;
  endfunction

  // compare one taken report with the oldest one due
  function void check_report(input lfr_result_t got);
    lfr_result_t want;
    if (due_reports.size() == 0) begin
      fail_note($sformatf("unexpected report kind %0d status %0d id %02h",
                          got.report_kind, got.status, got.frame_id));
      return;
    end
    want = due_reports.pop_front();
    if (want.report_kind == RPT_HEADER) headers++;
    else frames++;
    if (want.status == ST_CSUM_ERR) csum_errors++;
    if (got.report_kind !== want.report_kind || got.status !== want.status ||
        got.frame_id !== want.frame_id || got.data_length !== want.data_length ||
        got.data_bytes !== want.data_bytes ||
        got.received_checksum !== want.received_checksum) begin
      fail_note($sformatf({"exp kind %0d st %0d id %02h len %0d data %016h cs %02h | ",
                           "got kind %0d st %0d id %02h len %0d data %016h cs %02h"},
                          want.report_kind, want.status, want.frame_id, want.data_length,
                          want.data_bytes, want.received_checksum,
                          got.report_kind, got.status, got.frame_id, got.data_length,
                          got.data_bytes, got.received_checksum));
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;

  logic                clk;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  item_kind_e          in_kind;
  logic [LowTimeW-1:0] in_low;
  logic [7:0]          in_byte;
  logic                out_valid;
  logic                out_stall;
  logic                rpt_kind;
  logic [1:0]          rpt_status;
  logic [5:0]          rpt_id;
  logic [3:0]          rpt_len;
  logic [63:0]         rpt_data;
  logic [7:0]          rpt_csum;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_index_e          cfg_index;
  logic [BitTimeW-1:0] cfg_data;

  lin_report_checker   rx_model;
  logic                steady;
  logic [BitTimeW-1:0] cur_bit_time;
  logic                cur_enh;
  int unsigned         words_sent;
  int unsigned         frame_words;

  lin_frame_receiver_unit dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (in_kind),
    .low_time_us_i      (in_low),
    .rx_byte_i          (in_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .report_kind_o      (rpt_kind),
    .status_o           (rpt_status),
    .frame_id_o         (rpt_id),
    .data_length_o      (rpt_len),
    .data_bytes_o       (rpt_data),
    .received_checksum_o(rpt_csum),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // report side stalls at random, except in the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 21);
  end

  // take reports and input words as the edge sees them
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      rx_model.check_report({rpt_kind, rpt_status, rpt_id, rpt_len, rpt_data, rpt_csum});
    if (in_valid && !in_stall) rx_model.take_word(in_kind, in_low, in_byte);
  end

  // give up after a long run of cycles with no handshake at all
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles", StallLimit);
    $display("TB_ERROR");
    $finish;
  end

  // one word on the input channel; entered and left at a falling edge
  task automatic send_word(input item_kind_e k, input logic [LowTimeW-1:0] lt,
                           input logic [7:0] b);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_low   <= lt;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(KIND_BYTE, 16'($urandom), b);
  endtask

  task automatic send_line(input logic [LowTimeW-1:0] lt);
    send_word(KIND_LINE_RISE, lt, 8'($urandom));
  endtask

  function automatic logic [LowTimeW-1:0] break_low();
    int unsigned thr;
    thr = 32'(cur_bit_time) * 11;
    if ($urandom_range(3) == 0) return LowTimeW'(thr + 1);
    return LowTimeW'($urandom_range(65535, thr + 1));
  endfunction

  function automatic logic [LowTimeW-1:0] short_low();
    return LowTimeW'($urandom_range(32'(cur_bit_time) * 11));
  endfunction

  // stop sending and wait until every due report is out
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (rx_model.due_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_index_e idx, input logic [BitTimeW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rx_model.set_config(idx, d);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [BitTimeW-1:0] bt, input logic enh);
    settle();
    cfg_write(CFG_BIT_TIME, bt);
    cfg_write(CFG_CHECKSUM_ENHANCED, {9'($urandom), enh});
    cfg_valid <= 1'b0;
    cur_bit_time = bt;
    cur_enh = enh;
  endtask

  // mostly well-formed frame with random content; sometimes broken on purpose
  task automatic random_frame();
    logic [5:0]  id;
    logic [7:0]  pid;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [3:0]  len;
    int unsigned n;
    n = 0;
    id = 6'($urandom);
    pid = lin_pid(id);
    len = id_data_len(id);
    if ($urandom_range(9) == 0) send_line(short_low());
    send_line(break_low());
    n++;
    // stray bytes while armed are dropped
    if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) send_byte(8'($urandom_range(255, 1)));
    send_byte(BreakByte);
    n++;
    if ($urandom_range(9) == 0) begin
      send_byte(SyncByte ^ 8'($urandom_range(255, 1)));
      frame_words += n + 1;
      return;
    end
    send_byte(SyncByte);
    n++;
    if ($urandom_range(7) == 0) pid = pid ^ {2'($urandom_range(3, 1)), 6'd0};
    send_byte(pid);
    n++;
    if (pid != lin_pid(id)) begin
      frame_words += n;
      return;
    end
    sum = cur_enh ? pid : 8'h00;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_line(short_low());
      // new break mid-frame throws the frame away
      if ($urandom_range(39) == 0) begin
        send_line(break_low());
        frame_words += n + 1;
        return;
      end
      b = 8'($urandom);
      send_byte(b);
      n++;
      sum = eac_add(sum, b);
    end
    b = ~sum;
    if ($urandom_range(6) == 0) b = b ^ 8'($urandom_range(255, 1));
    send_byte(b);
    n++;
    frame_words += n;
  endtask

  task automatic random_noise();
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(1) == 1) send_byte(8'($urandom));
      else send_line(16'($urandom));
    end
  endtask

  task automatic random_run(input int unsigned goal);
    int unsigned stop_at;
    stop_at = frame_words + goal;
    while (frame_words < stop_at) begin
      if ($urandom_range(99) < 88) random_frame();
      else random_noise();
    end
  endtask

  // corner cases at the reset setting: 52 us bit time, classic checksum
  task automatic directed();
    send_byte(8'h00);                          // idle: dropped
    send_line(16'd0);
    send_line(16'd572);                        // exactly eleven bit times, no break
    send_line(16'hFFFF);
    send_byte(8'hFF);                          // armed, not a break byte
    send_byte(BreakByte);
    send_byte(8'hAA);                          // bad sync
    send_line(16'd573);
    send_byte(BreakByte);
    send_byte(SyncByte);
    send_byte(lin_pid(6'h3F) ^ ParityMask);    // both parity bits wrong
    // good short frame, short low in the middle is ignored
    send_line(16'd600);
    send_byte(BreakByte);
    send_byte(SyncByte);
    send_byte(lin_pid(6'h00));
    send_byte(8'h00);
    send_line(16'd100);
    send_byte(8'hFF);
    send_byte(~eac_add(8'h00, 8'hFF));
    // break during the data drops the frame, then a frame with a bad checksum
    send_line(16'd1000);
    send_byte(BreakByte);
    send_byte(SyncByte);
    send_byte(lin_pid(6'h2A));
    send_byte(8'h12);
    send_line(16'hFFFF);
    send_byte(BreakByte);
    send_byte(SyncByte);
    send_byte(lin_pid(6'h15));
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hA5);
  endtask

  initial begin : stimulus
    logic [BitTimeW-1:0] last_bt;
    rx_model     = new();
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_BYTE;
    in_low       = '0;
    in_byte      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_BIT_TIME;
    cfg_data     = '0;
    steady       = 1'b0;
    cur_bit_time = BitTimeReset;
    cur_enh      = 1'b0;
    words_sent   = 0;
    frame_words  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    directed();
    random_run(60);
    settle();                                  // drain fully mid-run
    random_run(60);
    apply_setting(10'd1, 1'b1);
    random_run(120);
    steady = 1'b1;
    apply_setting(10'd1023, 1'b0);
    random_run(120);
    steady = 1'b0;
    apply_setting(10'd0, 1'b1);                // any nonzero low time is a break
    random_run(120);
    last_bt = 10'($urandom_range(1000, 1));
    apply_setting(last_bt, 1'($urandom));
    random_run(120);

    // drain and let the pipeline go quiet
    in_valid <= 1'b0;
    @(negedge clk);
    while (rx_model.due_reports.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (rx_model.due_reports.size() != 0)
      rx_model.fail_note($sformatf("%0d reports never came", rx_model.due_reports.size()));

    $display("Sent %0d words; checked %0d header and %0d frame reports (%0d bad checksum)",
             words_sent, rx_model.headers, rx_model.frames, rx_model.csum_errors);
    $display("Bit times 52, 1, 1023, 0 and %0d, classic and enhanced sums; %0d failures",
             last_bt, rx_model.failures);
    if (rx_model.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== lin_frame_receiver_unit.f =====
sv/lfr_pkg.sv
sv/lfr_core.sv
sv/lfr_out_buf.sv
sv/lin_frame_receiver_unit.sv
bench/tb_top.sv
